// ===== rtl/periodic_timer_event_queue_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the periodic timer event queue
// Clock is "clock", checks are off while "reset" is high.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_EVENT_QUEUE_MACROS_SVH
`define PERIODIC_TIMER_EVENT_QUEUE_MACROS_SVH

// cons must hold in the same cycle as ante
`define PTEQ_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// cons must hold in the cycle after ante
`define PTEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/pteq_pkg.sv =====
// ----------------------------------------------------------------------------
// pteq_pkg
// Types and constants of the periodic timer event queue.
// ----------------------------------------------------------------------------
package pteq_pkg;

   // request opcodes
   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_START  = 2'd1;
   localparam logic [1:0] OP_EXPIRE = 2'd2;

   // ms to ticks: ms * 15.625 = (ms * 125) >> 3
   localparam int TICK_MULT  = 125;
   localparam int TICK_SHIFT = 3;

   typedef struct packed {
      logic [15:0] remaining;
      logic [15:0] period;
      logic [7:0]  ev_id;
   } entry_type;

   typedef struct packed {
      logic [7:0]  fired_id;
      logic        fired_valid;
      logic [15:0] compare_ticks;
      logic        compare_valid;
      logic        underflow;
      logic        full_drop;
   } result_type;

endpackage

// ===== rtl/pteq_ram.sv =====
// ----------------------------------------------------------------------------
// pteq_ram
// Simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pteq_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 32
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/periodic_timer_event_queue.sv =====
// ----------------------------------------------------------------------------
// periodic_timer_event_queue
// Flow: start goes S_IDLE, S_POP, S_RESP; add walks the N queued entries
//   (N = entries queued) in S_PASS before S_RESP, or goes straight to S_RESP
//   when the queue is full; expire walks in S_PASS, then S_POP_RD, S_POP,
//   S_RESP; ignored words go straight to S_RESP, which loads the output register.
// Throughput: one word at a time; the queue walk, one RAM entry per cycle,
//   runs for an expire and for an add that finds room.
// Reset: synchronous; empties the queue and clears the current event. The
//   entry RAM is not cleared, only entries below the count are ever used.
`include "periodic_timer_event_queue_macros.svh"

module periodic_timer_event_queue #(
   parameter int QUEUE_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [15:0] req_period_ms,
   input  logic [7:0]  req_event_id,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_fired_id,
   output logic        rsp_fired_valid,
   output logic [15:0] rsp_compare_ticks,
   output logic        rsp_compare_valid,
   output logic        rsp_underflow,
   output logic        rsp_full_drop
);

   import pteq_pkg::*;

   // AW: RAM address, CW: count / logical index, SW: head + index before wrap
   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = $clog2(2 * QUEUE_DEPTH);
   localparam int EW = $bits(entry_type);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_PASS   = 5'b00010,
      S_POP_RD = 5'b00100,
      S_POP    = 5'b01000,
      S_RESP   = 5'b10000
   } state_type;

   // The queue is a ring in the RAM: logical entry 0 (the soonest) sits at
   // head_ff. Pops only move the head. Inserts walk the ring from the head,
   // one entry per cycle, and bubble the tail of the ring back by one slot.
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                          input logic [CW-1:0] idx);
      logic [SW-1:0] sum;
      sum = SW'(head) + SW'(idx);
      if (sum >= SW'(QUEUE_DEPTH)) begin
         sum = sum - SW'(QUEUE_DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   state_type   state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] idx_ff, idx_in;         // logical entry whose read data is back
   logic        found_ff, found_in;       // insert slot already passed
   logic        ins_en_ff, ins_en_in;     // walk inserts new_ff at its slot
   logic        expire_ff, expire_in;     // walk belongs to an expire
   entry_type   carry_ff, carry_in;       // entry displaced one slot back
   entry_type   new_ff, new_in;
   logic [15:0] sub_ff, sub_in;           // amount taken off every remaining time
   result_type  res_ff, res_in;           // result being built

   logic [15:0] cur_interval_ff, cur_interval_in;
   logic [15:0] cur_period_ff, cur_period_in;
   logic [7:0]  cur_event_ff, cur_event_in;
   logic        active_ff, active_in;

   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_res_ff, rsp_res_in;

   // RAM side
   logic [CW-1:0] rd_idx;
   logic          wr_en;
   entry_type     wr_ent;
   logic [EW-1:0] ram_rd_data;
   entry_type     rd_ent;

   logic [22:0] tick_prod;
   logic [22:0] tick_raw;
   logic [15:0] ticks;

   entry_type   pass_ent;
   logic        in_range;
   logic        slot_hit;
   logic        has_room;

   // check terms
   logic        expire_acc;
   logic        pop_hit;

   pteq_ram #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (phys(head_ff, idx_ff)),
      .wr_data (wr_ent),
      .rd_addr (phys(head_ff, rd_idx)),
      .rd_data (ram_rd_data)
   );

   assign rd_ent = entry_type'(ram_rd_data);

   // period in ms to ticks, saturating at 16 bits
   assign tick_prod = 23'(req_period_ms) * 23'(TICK_MULT);
   assign tick_raw  = tick_prod >> TICK_SHIFT;
   assign ticks     = (|tick_raw[22:16]) ? 16'hFFFF : tick_raw[15:0];

   // entry coming back from the RAM, with the fired interval taken off
   always_comb begin
      pass_ent           = rd_ent;
      pass_ent.remaining = rd_ent.remaining - sub_ff;
   end

   assign in_range  = idx_ff < count_ff;
   assign slot_hit  = ins_en_ff && !found_ff && (pass_ent.remaining >= new_ff.remaining);
   assign has_room  = count_ff < CW'(QUEUE_DEPTH);
   assign req_stall = state_ff != S_IDLE;

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      head_in         = head_ff;
      idx_in          = idx_ff;
      found_in        = found_ff;
      ins_en_in       = ins_en_ff;
      expire_in       = expire_ff;
      carry_in        = carry_ff;
      new_in          = new_ff;
      sub_in          = sub_ff;
      res_in          = res_ff;
      cur_interval_in = cur_interval_ff;
      cur_period_in   = cur_period_ff;
      cur_event_in    = cur_event_ff;
      active_in       = active_ff;
      rsp_res_in      = rsp_res_ff;
      rsp_valid_in    = rsp_valid_ff;
      rd_idx          = '0;        // idle: keep the head entry on the read port
      wr_en           = 1'b0;
      wr_ent          = pass_ent;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_in    = '0;
               idx_in    = '0;
               found_in  = 1'b0;
               expire_in = 1'b0;
               state_in  = S_RESP;
               case (req_opcode)
                  OP_ADD: begin
                     new_in    = '{remaining: ticks, period: ticks, ev_id: req_event_id};
                     sub_in    = '0;
                     ins_en_in = 1'b1;
                     if (has_room) begin
                        state_in = S_PASS;
                     end else begin
                        res_in.full_drop = 1'b1;
                     end
                  end
                  OP_START: begin
                     // head entry is already on the read port
                     state_in = S_POP;
                  end
                  OP_EXPIRE: begin
                     // no current event: word answers all zero
                     if (active_ff) begin
                        res_in.fired_id    = cur_event_ff;
                        res_in.fired_valid = 1'b1;
                        res_in.full_drop   = !has_room;
                        new_in    = '{remaining: cur_period_ff, period: cur_period_ff,
                                      ev_id: cur_event_ff};
                        sub_in    = cur_interval_ff;
                        ins_en_in = has_room;
                        expire_in = 1'b1;
                        state_in  = S_PASS;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end

         S_PASS: begin
            if (in_range) begin
               // write back entry idx, fetch idx+1
               rd_idx = idx_ff + 1'b1;
               wr_en  = 1'b1;
               if (slot_hit) begin
                  wr_ent   = new_ff;
                  carry_in = pass_ent;
                  found_in = 1'b1;
               end else if (found_ff) begin
                  wr_ent   = carry_ff;
                  carry_in = pass_ent;
               end
               idx_in = idx_ff + 1'b1;
            end else begin
               // one slot past the tail: last displaced entry, or new at tail
               if (ins_en_ff) begin
                  wr_en    = 1'b1;
                  wr_ent   = found_ff ? carry_ff : new_ff;
                  count_in = count_ff + 1'b1;
               end
               state_in = expire_ff ? S_POP_RD : S_RESP;
            end
         end

         S_POP_RD: begin
            // walk writes are done; read the new head
            state_in = S_POP;
         end

         S_POP: begin
            if (count_ff == '0) begin
               res_in.underflow = 1'b1;
            end else begin
               cur_interval_in      = rd_ent.remaining;
               cur_period_in        = rd_ent.period;
               cur_event_in         = rd_ent.ev_id;
               active_in            = 1'b1;
               head_in              = phys(head_ff, CW'(1));
               count_in             = count_ff - 1'b1;
               res_in.compare_ticks = rd_ent.remaining;
               res_in.compare_valid = 1'b1;
            end
            state_in = S_RESP;
         end

         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_res_in   = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         count_ff        <= '0;
         head_ff         <= '0;
         cur_interval_ff <= '0;
         cur_period_ff   <= '0;
         cur_event_ff    <= '0;
         active_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         count_ff        <= count_in;
         head_ff         <= head_in;
         cur_interval_ff <= cur_interval_in;
         cur_period_ff   <= cur_period_in;
         cur_event_ff    <= cur_event_in;
         active_ff       <= active_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // walk payload, set up on every accepted word
   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      found_ff   <= found_in;
      ins_en_ff  <= ins_en_in;
      expire_ff  <= expire_in;
      carry_ff   <= carry_in;
      new_ff     <= new_in;
      sub_ff     <= sub_in;
      res_ff     <= res_in;
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fired_id      = rsp_res_ff.fired_id;
   assign rsp_fired_valid   = rsp_res_ff.fired_valid;
   assign rsp_compare_ticks = rsp_res_ff.compare_ticks;
   assign rsp_compare_valid = rsp_res_ff.compare_valid;
   assign rsp_underflow     = rsp_res_ff.underflow;
   assign rsp_full_drop     = rsp_res_ff.full_drop;

   // checks
   assign expire_acc = req_valid && !req_stall && req_opcode == OP_EXPIRE && active_ff;
   assign pop_hit    = state_ff == S_POP && count_ff != '0;

   `PTEQ_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CW'(QUEUE_DEPTH), "count above depth")
   `PTEQ_ASSERT_NOW(a_walk_index, state_ff == S_PASS, idx_ff <= count_ff, "walk past tail")
   `PTEQ_ASSERT_NEXT(a_expire_walk, expire_acc, state_ff == S_PASS, "expire did not walk")
   `PTEQ_ASSERT_NEXT(a_pop_count, pop_hit, count_ff == $past(count_ff) - 1'b1, "pop kept count")
   `PTEQ_ASSERT_NOW(a_active_holds, 1'b1, !$fell(active_ff), "current event lost")

endmodule
